### rtl/assert_macros.svh
// Concurrent assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, held off during reset.
`define ASSERT_IMPLIES(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed: ante implies cons");

// Next-cycle implication, held off during reset.
`define ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed: ante implies cons next cycle");

`endif

### rtl/fcgi_pkg.sv
package fcgi_pkg;

   // Width of a decoded name or value length before saturation (8 to 31).
   localparam int PARAM_LENGTH_BITS = 31;
   localparam logic [30:0] LEN_MAX = 31'((64'd1 << PARAM_LENGTH_BITS) - 64'd1);

   localparam logic [7:0]  TYPE_BEGIN     = 8'd1;
   localparam logic [7:0]  TYPE_PARAMS    = 8'd4;
   localparam logic [7:0]  TYPE_STDIN     = 8'd5;
   localparam logic [15:0] ROLE_RESPONDER = 16'd1;
   localparam logic [7:0]  KEEP_CONN      = 8'd1;

   typedef enum logic [1:0] {
      SEG_HEADER  = 2'd0,
      SEG_CONTENT = 2'd1,
      SEG_PADDING = 2'd2
   } seg_type;

   localparam logic [2:0] PART_NONE       = 3'd0;
   localparam logic [2:0] PART_NAME_LEN   = 3'd1;
   localparam logic [2:0] PART_VALUE_LEN  = 3'd2;
   localparam logic [2:0] PART_NAME_DATA  = 3'd3;
   localparam logic [2:0] PART_VALUE_DATA = 3'd4;

   typedef enum logic [1:0] {
      PH_NAME_LEN   = 2'd0,
      PH_VALUE_LEN  = 2'd1,
      PH_NAME_DATA  = 2'd2,
      PH_VALUE_DATA = 2'd3
   } pair_phase_type;

   typedef struct packed {
      logic step;   // a params content byte is transferred
      logic clear;  // return the pair decoder to idle
   } pair_ctrl_type;

   typedef struct packed {
      logic [2:0]  part;
      logic        len_ready;
      logic [30:0] len;
      logic        open;   // a name-value pair is incomplete
   } pair_stat_type;

endpackage

### rtl/fcgi_if.sv
interface fcgi_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;

   modport source (output valid, output data_byte, input ready);
   modport sink   (input valid, input data_byte, output ready);
endinterface

interface fcgi_rsp_if;
   logic        valid;
   logic        ready;
   logic [7:0]  byte_out;
   logic [1:0]  segment;
   logic [7:0]  record_kind;
   logic [15:0] request_ident;
   logic        record_last;
   logic [2:0]  param_part;
   logic        length_ready;
   logic [30:0] decoded_length;
   logic        param_error;
   logic        keep_open;
   logic        request_done;

   modport source (output valid, output byte_out, output segment, output record_kind,
                   output request_ident, output record_last, output param_part,
                   output length_ready, output decoded_length, output param_error,
                   output keep_open, output request_done, input ready);
   modport sink   (input valid, input byte_out, input segment, input record_kind,
                   input request_ident, input record_last, input param_part,
                   input length_ready, input decoded_length, input param_error,
                   input keep_open, input request_done, output ready);
endinterface

### rtl/fcgi_pair_dec.sv
module fcgi_pair_dec (
   input  logic                   clock,
   input  logic                   reset,
   input  fcgi_pkg::pair_ctrl_type ctrl,
   input  logic [7:0]             data_byte,
   output fcgi_pkg::pair_stat_type stat
);

   fcgi_pkg::pair_phase_type phase_ff, phase_in;
   logic [30:0] accum_ff, accum_in;
   logic [1:0]  lbl_ff, lbl_in;
   logic [30:0] dl_ff, dl_in;

   logic        len_done;
   logic [30:0] len_val;
   logic [30:0] acc_step;
   logic [1:0]  lbl_step;
   logic [30:0] dl_dec;
   logic        is_len;

   // Length byte datapath: one byte, or four with the top bit of the first set.
   always_comb begin
      len_done = 1'b0;
      len_val  = '0;
      acc_step = accum_ff;
      lbl_step = lbl_ff;
      if (lbl_ff == 2'd0) begin
         if (data_byte[7]) begin
            acc_step = {24'd0, data_byte[6:0]};
            lbl_step = 2'd3;
         end else begin
            len_val  = {23'd0, data_byte};
            len_done = 1'b1;
         end
      end else begin
         acc_step = {accum_ff[22:0], data_byte};
         lbl_step = lbl_ff - 2'd1;
         if (lbl_ff == 2'd1) begin
            len_val  = (acc_step > fcgi_pkg::LEN_MAX) ? fcgi_pkg::LEN_MAX : acc_step;
            len_done = 1'b1;
         end
      end
      dl_dec = (dl_ff != '0) ? dl_ff - 31'd1 : '0;
   end

   // Next state
   always_comb begin
      phase_in = phase_ff;
      accum_in = accum_ff;
      lbl_in   = lbl_ff;
      dl_in    = dl_ff;
      if (ctrl.clear) begin
         phase_in = fcgi_pkg::PH_NAME_LEN;
         accum_in = '0;
         lbl_in   = '0;
         dl_in    = '0;
      end else if (ctrl.step) begin
         case (phase_ff)
            fcgi_pkg::PH_NAME_LEN: begin
               accum_in = acc_step;
               lbl_in   = lbl_step;
               if (len_done) begin
                  dl_in    = len_val;
                  accum_in = '0;
                  phase_in = fcgi_pkg::PH_VALUE_LEN;
               end
            end
            fcgi_pkg::PH_VALUE_LEN: begin
               accum_in = acc_step;
               lbl_in   = lbl_step;
               if (len_done) begin
                  accum_in = len_val;
                  if (dl_ff != '0) begin
                     phase_in = fcgi_pkg::PH_NAME_DATA;
                  end else if (len_val != '0) begin
                     // empty name: go straight to the value data
                     dl_in    = len_val;
                     phase_in = fcgi_pkg::PH_VALUE_DATA;
                  end else begin
                     phase_in = fcgi_pkg::PH_NAME_LEN;
                  end
               end
            end
            fcgi_pkg::PH_NAME_DATA: begin
               dl_in = dl_dec;
               if (dl_dec == '0) begin
                  if (accum_ff != '0) begin
                     dl_in    = accum_ff;
                     phase_in = fcgi_pkg::PH_VALUE_DATA;
                  end else begin
                     phase_in = fcgi_pkg::PH_NAME_LEN;
                  end
               end
            end
            default: begin
               dl_in = dl_dec;
               if (dl_dec == '0) begin
                  phase_in = fcgi_pkg::PH_NAME_LEN;
               end
            end
         endcase
      end
   end

   // Outputs
   always_comb begin
      is_len = (phase_ff == fcgi_pkg::PH_NAME_LEN) || (phase_ff == fcgi_pkg::PH_VALUE_LEN);
      case (phase_ff)
         fcgi_pkg::PH_NAME_LEN:   stat.part = fcgi_pkg::PART_NAME_LEN;
         fcgi_pkg::PH_VALUE_LEN:  stat.part = fcgi_pkg::PART_VALUE_LEN;
         fcgi_pkg::PH_NAME_DATA:  stat.part = fcgi_pkg::PART_NAME_DATA;
         default:                 stat.part = fcgi_pkg::PART_VALUE_DATA;
      endcase
      stat.len_ready = is_len && len_done;
      stat.len       = (is_len && len_done) ? len_val : '0;
      stat.open      = (phase_ff != fcgi_pkg::PH_NAME_LEN) || (lbl_ff != 2'd0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= fcgi_pkg::PH_NAME_LEN;
         accum_ff <= '0;
         lbl_ff   <= '0;
         dl_ff    <= '0;
      end else begin
         phase_ff <= phase_in;
         accum_ff <= accum_in;
         lbl_ff   <= lbl_in;
         dl_ff    <= dl_in;
      end
   end

endmodule

### rtl/fcgi_record_deframer.sv
// FastCGI record deframer. Takes one stream byte per transfer and returns one
// tagged result per byte, in the cycle after the byte is accepted. A byte can be
// accepted in every cycle: the only stall is a result in the output register
// that the sink has not yet taken, so the sustained rate is one byte per clock.
// The rate is set by the single registered pass from the framing counters and
// the params pair decoder into the result register. Record type and request id
// show partial values while the header is still arriving.
`include "assert_macros.svh"

module fcgi_record_deframer (
   input logic        clock,
   input logic        reset,
   fcgi_req_if.sink   req_if,
   fcgi_rsp_if.source rsp_if
);

   localparam logic [2:0] HB_START    = 3'd0;
   localparam logic [2:0] HB_TYPE     = 3'd1;
   localparam logic [2:0] HB_ID_HI    = 3'd2;
   localparam logic [2:0] HB_ID_LO    = 3'd3;
   localparam logic [2:0] HB_LEN_HI   = 3'd4;
   localparam logic [2:0] HB_LEN_LO   = 3'd5;
   localparam logic [2:0] HB_PAD      = 3'd6;

   logic        accept;
   logic        valid_ff;

   logic [2:0]  hdr_ff, hdr_in;
   logic [7:0]  type_ff, type_in;
   logic [15:0] ident_ff, ident_in;
   logic [15:0] cl_ff, cl_in;
   logic [7:0]  pl_ff, pl_in;
   logic [15:0] off_ff, off_in;
   logic [15:0] role_ff, role_in;
   logic        keep_ff, keep_in;

   logic [16:0] total;
   fcgi_pkg::seg_type seg;
   logic        last, perr, done, params_byte;
   logic [7:0]  b;

   fcgi_pkg::pair_ctrl_type pair_ctrl;
   fcgi_pkg::pair_stat_type pair_stat;

   // Output register payload
   logic [7:0]  byte_ff;
   logic [1:0]  seg_ff;
   logic [7:0]  kind_ff;
   logic [15:0] rid_ff;
   logic        last_ff;
   logic [2:0]  part_ff;
   logic        lrdy_ff;
   logic [30:0] dlen_ff;
   logic        perr_ff;
   logic        keepo_ff;
   logic        done_ff;

   assign req_if.ready = !reset && (!valid_ff || rsp_if.ready);
   assign accept       = req_if.valid && req_if.ready;
   assign b            = req_if.data_byte;

   always_comb begin
      hdr_in      = hdr_ff;
      type_in     = type_ff;
      ident_in    = ident_ff;
      cl_in       = cl_ff;
      pl_in       = pl_ff;
      off_in      = off_ff;
      role_in     = role_ff;
      keep_in     = keep_ff;
      seg         = fcgi_pkg::SEG_HEADER;
      last        = 1'b0;
      perr        = 1'b0;
      done        = 1'b0;
      params_byte = 1'b0;
      pair_ctrl   = '0;
      total       = {1'b0, off_ff} + {1'b0, cl_ff};

      if (hdr_ff != 3'd0 || (cl_ff == '0 && pl_ff == '0)) begin
         case (hdr_ff)
            HB_START:  off_in = '0;
            HB_TYPE:   type_in = b;
            HB_ID_HI:  ident_in = {b, ident_ff[7:0]};
            HB_ID_LO:  ident_in = {ident_ff[15:8], b};
            HB_LEN_HI: cl_in = {b, 8'd0};
            HB_LEN_LO: cl_in = {cl_ff[15:8], b};
            HB_PAD:    pl_in = b;
            default: begin
               last = (cl_ff == '0) && (pl_ff == '0);
               if (type_ff == fcgi_pkg::TYPE_PARAMS && cl_ff == '0) begin
                  perr            = pair_stat.open;
                  pair_ctrl.clear = 1'b1;
               end
            end
         endcase
         hdr_in = hdr_ff + 3'd1;
      end else if (cl_ff != '0) begin
         seg    = fcgi_pkg::SEG_CONTENT;
         cl_in  = cl_ff - 16'd1;
         off_in = off_ff + 16'd1;
         if (type_ff == fcgi_pkg::TYPE_BEGIN) begin
            if (off_ff == 16'd0) begin
               role_in = {b, role_ff[7:0]};
            end else if (off_ff == 16'd1) begin
               role_in = {role_ff[15:8], b};
            end else if (off_ff == 16'd2 && total >= 17'd8 &&
                         role_ff == fcgi_pkg::ROLE_RESPONDER) begin
               keep_in = (b == fcgi_pkg::KEEP_CONN);
            end
         end else if (type_ff == fcgi_pkg::TYPE_PARAMS) begin
            params_byte    = 1'b1;
            pair_ctrl.step = 1'b1;
         end
         last = (cl_in == '0) && (pl_ff == '0);
      end else begin
         seg   = fcgi_pkg::SEG_PADDING;
         pl_in = pl_ff - 8'd1;
         last  = (pl_in == '0);
      end

      // empty stdin record ends the request
      if (last && type_in == fcgi_pkg::TYPE_STDIN && off_in == '0) begin
         done            = 1'b1;
         pair_ctrl.clear = 1'b1;
      end

      pair_ctrl.step  = pair_ctrl.step && accept;
      pair_ctrl.clear = pair_ctrl.clear && accept;
   end

   fcgi_pair_dec u_pair (
      .clock     (clock),
      .reset     (reset),
      .ctrl      (pair_ctrl),
      .data_byte (b),
      .stat      (pair_stat)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         hdr_ff   <= '0;
         type_ff  <= '0;
         ident_ff <= '0;
         cl_ff    <= '0;
         pl_ff    <= '0;
         off_ff   <= '0;
         role_ff  <= '0;
         keep_ff  <= 1'b0;
         valid_ff <= 1'b0;
      end else begin
         if (accept) begin
            hdr_ff   <= hdr_in;
            type_ff  <= type_in;
            ident_ff <= ident_in;
            cl_ff    <= cl_in;
            pl_ff    <= pl_in;
            off_ff   <= off_in;
            role_ff  <= role_in;
            keep_ff  <= keep_in;
         end
         if (accept) begin
            valid_ff <= 1'b1;
         end else if (rsp_if.ready) begin
            valid_ff <= 1'b0;
         end
      end
   end

   // Result register: load on every input transfer, hold while stalled
   always_ff @(posedge clock) begin
      if (accept) begin
         byte_ff  <= b;
         seg_ff   <= seg;
         kind_ff  <= type_in;
         rid_ff   <= ident_in;
         last_ff  <= last;
         part_ff  <= params_byte ? pair_stat.part : fcgi_pkg::PART_NONE;
         lrdy_ff  <= params_byte && pair_stat.len_ready;
         dlen_ff  <= params_byte ? pair_stat.len : '0;
         perr_ff  <= perr;
         keepo_ff <= keep_in;
         done_ff  <= done;
      end
   end

   assign rsp_if.valid          = valid_ff;
   assign rsp_if.byte_out       = byte_ff;
   assign rsp_if.segment        = seg_ff;
   assign rsp_if.record_kind    = kind_ff;
   assign rsp_if.request_ident  = rid_ff;
   assign rsp_if.record_last    = last_ff;
   assign rsp_if.param_part     = part_ff;
   assign rsp_if.length_ready   = lrdy_ff;
   assign rsp_if.decoded_length = dlen_ff;
   assign rsp_if.param_error    = perr_ff;
   assign rsp_if.keep_open      = keepo_ff;
   assign rsp_if.request_done   = done_ff;

   `ASSERT_NEXT(a_accept_fills, clock, reset, accept, valid_ff)
   `ASSERT_IMPLIES(a_len_in_params, clock, reset, valid_ff && lrdy_ff,
      seg_ff == fcgi_pkg::SEG_CONTENT && kind_ff == fcgi_pkg::TYPE_PARAMS)
   `ASSERT_IMPLIES(a_done_on_last, clock, reset, valid_ff && done_ff, last_ff)
   `ASSERT_IMPLIES(a_err_in_header, clock, reset, valid_ff && perr_ff,
      seg_ff == fcgi_pkg::SEG_HEADER && kind_ff == fcgi_pkg::TYPE_PARAMS)

endmodule
